[rtl/mi_pkg.sv]
// shared types and defaults for the modular inverse block
package mi_pkg;

    localparam int VALUE_BITS_DEFAULT = 31;

    // status of the shared divide step unit
    typedef struct packed {
        logic busy;
        logic done;
    } mi_step_stat_t;

endpackage

[rtl/mi_step.sv]
// one euclid step: restoring divide with shift-add of quotient times coefficient
module mi_step #(
    parameter int VALUE_BITS = mi_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [VALUE_BITS-1:0]        dividend,
    input  logic [VALUE_BITS-1:0]        divisor,
    input  logic signed [VALUE_BITS+1:0] coef,
    output logic [VALUE_BITS-1:0]        rem,
    output logic signed [VALUE_BITS+1:0] prod,
    output mi_pkg::mi_step_stat_t        stat
);

    localparam int SW = VALUE_BITS + 2;
    localparam int CW = $clog2(VALUE_BITS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CW-1:0]        cnt_reg;
    logic [VALUE_BITS-1:0] div_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic signed [SW-1:0] prod_reg;

    logic [VALUE_BITS:0]  rem_shift;
    logic [VALUE_BITS:0]  rem_diff;
    logic                 qbit;
    logic signed [SW-1:0] prod_add;

    always_comb
    begin
        rem_shift = {rem_reg, div_reg[VALUE_BITS-1]};
        rem_diff  = rem_shift - {1'b0, divisor};
        qbit      = (rem_shift >= {1'b0, divisor});
        prod_add  = (prod_reg <<< 1) + (qbit ? coef : SW'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(VALUE_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg  <= dividend;
            rem_reg  <= '0;
            prod_reg <= '0;
        end
        else if (busy_reg)
        begin
            div_reg  <= div_reg << 1;
            rem_reg  <= qbit ? rem_diff[VALUE_BITS-1:0] : rem_shift[VALUE_BITS-1:0];
            prod_reg <= prod_add;
        end
    end

    assign rem       = rem_reg;
    assign prod      = prod_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[rtl/modular_inverse_top.sv]
// modular inverse by extended euclid, sequencer around a shared divide step
// One word in, one word out. For a zero modulus no divide step is run and the result word
// goes straight to the output slot. Otherwise each euclid step starts the shared restoring
// divider, which works one quotient bit per cycle (with the quotient-times-coefficient
// product built alongside), and then takes the step's result. The number of steps is that
// of the euclid remainder sequence, at most about 46 for 31-bit operands. The input stalls
// while an item is in work; a new word is taken while the previous result still waits.
module modular_inverse_top #(
    parameter int VALUE_BITS = mi_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [VALUE_BITS-1:0] modulus,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_BITS-1:0] inverse,
    output logic                  exists
);

    localparam int SW = VALUE_BITS + 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIX,
        S_OUT
    } state_t;

    state_t                state_reg;
    logic                  start_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [VALUE_BITS-1:0] m_reg;
    logic [VALUE_BITS-1:0] prev_r_reg;
    logic [VALUE_BITS-1:0] cur_r_reg;
    logic signed [SW-1:0]  prev_s_reg;
    logic signed [SW-1:0]  cur_s_reg;
    logic [VALUE_BITS-1:0] res_reg;
    logic                  ex_reg;
    logic [VALUE_BITS-1:0] inverse_reg;
    logic                  exists_reg;

    logic [VALUE_BITS-1:0] step_rem;
    logic signed [SW-1:0]  step_prod;
    mi_pkg::mi_step_stat_t step_stat;

    logic signed [SW-1:0]  s_new;
    logic signed [SW-1:0]  m_ext;
    logic signed [SW-1:0]  fix_val;
    logic                  accept;
    logic                  out_free;

    mi_step #(
        .VALUE_BITS(VALUE_BITS)
    ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (prev_r_reg),
        .divisor  (cur_r_reg),
        .coef     (cur_s_reg),
        .rem      (step_rem),
        .prod     (step_prod),
        .stat     (step_stat)
    );

    always_comb
    begin
        accept   = in_valid && (state_reg == S_IDLE);
        out_free = !out_valid_reg || !out_stall;
        // a waiting word stays until taken; a new one is loaded when the slot is free
        out_valid_next = out_valid_reg && out_stall;
        if ((state_reg == S_OUT) && out_free)
        begin
            out_valid_next = 1'b1;
        end
        s_new    = prev_s_reg - step_prod;
        m_ext    = $signed({2'b00, m_reg});
        // coefficient magnitude stays within the modulus, one correction suffices
        if (prev_s_reg < 0)
        begin
            fix_val = prev_s_reg + m_ext;
        end
        else if (prev_s_reg >= m_ext)
        begin
            fix_val = prev_s_reg - m_ext;
        end
        else
        begin
            fix_val = prev_s_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            inverse_reg   <= '0;
            exists_reg    <= 1'b0;
        end
        else
        begin
            start_reg     <= 1'b0;
            out_valid_reg <= out_valid_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (modulus == '0)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            start_reg <= 1'b1;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (step_stat.done)
                    begin
                        if (step_rem == '0)
                        begin
                            state_reg <= S_FIX;
                        end
                        else
                        begin
                            start_reg <= 1'b1;
                        end
                    end
                end
                S_FIX:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        inverse_reg <= res_reg;
                        exists_reg  <= ex_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    m_reg      <= modulus;
                    prev_r_reg <= value;
                    cur_r_reg  <= modulus;
                    prev_s_reg <= SW'(1);
                    cur_s_reg  <= '0;
                    res_reg    <= '0;
                    ex_reg     <= 1'b0;
                end
            end
            S_DIV:
            begin
                if (step_stat.done)
                begin
                    prev_r_reg <= cur_r_reg;
                    cur_r_reg  <= step_rem;
                    prev_s_reg <= cur_s_reg;
                    cur_s_reg  <= s_new;
                end
            end
            S_FIX:
            begin
                if (prev_r_reg == VALUE_BITS'(1))
                begin
                    res_reg <= fix_val[VALUE_BITS-1:0];
                    ex_reg  <= 1'b1;
                end
                else
                begin
                    res_reg <= '0;
                    ex_reg  <= 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign inverse   = inverse_reg;
    assign exists    = exists_reg;

endmodule
